@@ rtl/core/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types, constants and tables of the UTF-8 stream decoder
// Byte classes, the automaton transition table, case-mapping modes and the
// result of one decoder step.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 4;
  localparam int unsigned StateW = 4;
  localparam int unsigned CpW    = 21;
  localparam int unsigned ModeW  = 2;

  localparam logic [StateW-1:0] StAccept = 4'd0;
  localparam logic [StateW-1:0] StReject = 4'd1;

  localparam logic [CpW-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CpAsciiMax    = 21'h00007F;

  // ASCII case-mapping modes held in the configuration register.
  typedef enum logic [ModeW-1:0] {
    CASE_NONE       = 2'd0,
    CASE_UPPER      = 2'd1,
    CASE_LOWER      = 2'd2,
    CASE_CAPITALIZE = 2'd3
  } case_mode_e;

  // Outcome of one automaton step for one byte.
  typedef struct packed {
    logic [StateW-1:0] next_state;
    logic [CpW-1:0]    next_partial;
    logic              emit;
    logic [CpW-1:0]    code_point;
    logic              invalid;
  } u8dec_step_t;

  // Maps a raw byte to its class.
  function automatic logic [ClassW-1:0] byte_class(input logic [ByteW-1:0] b);
    logic [ClassW-1:0] c;
    c = 4'd8;
    if (b <= 8'h7F)                    c = 4'd0;
    else if (b <= 8'h8F)               c = 4'd1;
    else if (b <= 8'h9F)               c = 4'd9;
    else if (b <= 8'hBF)               c = 4'd7;
    else if (b <= 8'hC1)               c = 4'd8;
    else if (b <= 8'hDF)               c = 4'd2;
    else if (b == 8'hE0)               c = 4'd10;
    else if (b == 8'hED)               c = 4'd4;
    else if (b <= 8'hEF)               c = 4'd3;
    else if (b == 8'hF0)               c = 4'd11;
    else if (b <= 8'hF3)               c = 4'd6;
    else if (b == 8'hF4)               c = 4'd5;
    return c;
  endfunction

  // Transition table; every pair not listed leads to the reject state.
  function automatic logic [StateW-1:0] next_state(input logic [StateW-1:0] s,
                                                   input logic [ClassW-1:0] c);
    logic [StateW-1:0] n;
    n = StReject;
    case (s)
      4'd0: begin
        case (c)
          4'd0:    n = 4'd0;
          4'd2:    n = 4'd2;
          4'd3:    n = 4'd3;
          4'd4:    n = 4'd5;
          4'd5:    n = 4'd8;
          4'd6:    n = 4'd7;
          4'd10:   n = 4'd4;
          4'd11:   n = 4'd6;
          default: n = StReject;
        endcase
      end
      4'd2: if (c == 4'd1 || c == 4'd7 || c == 4'd9) n = 4'd0;
      4'd3: if (c == 4'd1 || c == 4'd7 || c == 4'd9) n = 4'd2;
      4'd4: if (c == 4'd7) n = 4'd2;
      4'd5: if (c == 4'd1 || c == 4'd9) n = 4'd2;
      4'd6: if (c == 4'd7 || c == 4'd9) n = 4'd3;
      4'd7: if (c == 4'd1 || c == 4'd7 || c == 4'd9) n = 4'd3;
      4'd8: if (c == 4'd1) n = 4'd3;
      default: n = StReject;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/u8dec_if.sv @@
// ----------------------------------------------------------------------------
// u8dec interfaces: byte input, code point output and configuration channels
// Each channel carries valid, ready and its payload; an item moves at a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface u8dec_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::ByteW-1:0] in_byte;
  logic                        first_char;
  modport source (output valid, output in_byte, output first_char, input ready);
  modport sink   (input valid, input in_byte, input first_char, output ready);
endinterface

interface u8dec_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8dec_pkg::CpW-1:0] code_point;
  logic                      invalid;
  modport source (output valid, output code_point, output invalid, input ready);
  modport sink   (input valid, input code_point, input invalid, output ready);
endinterface

interface u8dec_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::ModeW-1:0] case_mode;
  modport source (output valid, output case_mode, input ready);
  modport sink   (input valid, input case_mode, output ready);
endinterface

@@ rtl/core/utf8_stream_decoder_with_case_core.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_with_case_core: UTF-8 byte stream to code points
// Decodes one byte per item with a table-driven automaton and case-maps
// ASCII results according to the configured mode.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                       Note
//   in_i     in   in_byte[7:0], first_char      one stream byte per item
//   out_o    out  code_point[20:0], invalid     zero or one item per byte
//   cfg_i    in   case_mode[1:0]                always ready
//
// Throughput is one byte per cycle while a result does not stall. A byte
// taken sits in the input register, steps the automaton from there, and its
// result is held in the result register. The automaton state feeds back
// around the single step stage. Reset clears state, partial code, case
// mode and valid flags. A stalled result holds in the result register while
// the byte behind it still steps if it emits nothing.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_with_case_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8dec_in_if.sink      in_i,
  u8dec_out_if.source   out_o,
  u8dec_cfg_if.sink     cfg_i
);

  logic                         s1_valid_q;
  logic [u8dec_pkg::ByteW-1:0]  s1_byte_q;
  logic                         s1_first_q;
  logic [u8dec_pkg::StateW-1:0] state_q;
  logic [u8dec_pkg::CpW-1:0]    partial_q;
  u8dec_pkg::case_mode_e        mode_q;
  logic                         out_valid_q;
  logic [u8dec_pkg::CpW-1:0]    out_cp_q;
  logic                         out_inv_q;
  u8dec_pkg::u8dec_step_t       step;
  logic                         advance;
  logic                         in_take;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= u8dec_pkg::CASE_NONE;
    end else if (cfg_i.valid) begin
      mode_q <= u8dec_pkg::case_mode_e'(cfg_i.case_mode);
    end
  end

  // Automaton step on the registered byte.
  u8dec_step u_step (
    .state_i   (state_q),
    .partial_i (partial_q),
    .byte_i    (s1_byte_q),
    .first_i   (s1_first_q),
    .mode_i    (mode_q),
    .step_o    (step)
  );

  // The byte steps when its result has room or it produces none.
  assign advance = s1_valid_q && (!out_valid_q || out_o.ready || !step.emit);
  assign in_take = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= in_i.in_byte;
      s1_first_q <= in_i.first_char;
    end
  end

  // Automaton state and partial code point.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= u8dec_pkg::StAccept;
      partial_q <= '0;
    end else if (advance) begin
      state_q   <= step.next_state;
      partial_q <= step.next_partial;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.emit) begin
      out_cp_q  <= step.code_point;
      out_inv_q <= step.invalid;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = out_cp_q;
  assign out_o.invalid    = out_inv_q;

endmodule

@@ rtl/core/u8dec_step.sv @@
// ----------------------------------------------------------------------------
// u8dec_step: one decoder automaton step
// Classifies the byte, looks up the next state, gathers payload bits and
// applies the ASCII case mapping to a completed code point.
// ----------------------------------------------------------------------------
module u8dec_step (
  input  logic [u8dec_pkg::StateW-1:0] state_i,
  input  logic [u8dec_pkg::CpW-1:0]    partial_i,
  input  logic [u8dec_pkg::ByteW-1:0]  byte_i,
  input  logic                         first_i,
  input  u8dec_pkg::case_mode_e        mode_i,
  output u8dec_pkg::u8dec_step_t       step_o
);

  logic [u8dec_pkg::ClassW-1:0] cls;
  logic [u8dec_pkg::StateW-1:0] nxt;
  logic [u8dec_pkg::CpW-1:0]    gathered;
  logic [u8dec_pkg::ByteW-1:0]  lead_mask;
  logic                         is_lower;
  logic                         is_upper;
  logic [u8dec_pkg::CpW-1:0]    mapped;

  // Byte class and transition; states beyond the table reject.
  assign cls = u8dec_pkg::byte_class(byte_i);
  assign nxt = u8dec_pkg::next_state(state_i, cls);

  // A lead byte keeps the bits its class leaves; a continuation shifts in six.
  assign lead_mask = 8'hFF >> cls;
  assign gathered  = (state_i != u8dec_pkg::StAccept)
                   ? {partial_i[u8dec_pkg::CpW-7:0], byte_i[5:0]}
                   : {13'd0, lead_mask & byte_i};

  // ASCII letters only; everything else passes unchanged.
  assign is_lower = (gathered >= 21'h61) && (gathered <= 21'h7A);
  assign is_upper = (gathered >= 21'h41) && (gathered <= 21'h5A);

  always_comb begin
    mapped = gathered;
    if (gathered <= u8dec_pkg::CpAsciiMax) begin
      case (mode_i)
        u8dec_pkg::CASE_UPPER: if (is_lower) mapped = gathered - 21'h20;
        u8dec_pkg::CASE_LOWER: if (is_upper) mapped = gathered + 21'h20;
        u8dec_pkg::CASE_CAPITALIZE: if (first_i && is_lower) mapped = gathered - 21'h20;
        default: mapped = gathered;
      endcase
    end
  end

  // Step outcome: reject emits the replacement, accept emits the code point.
  always_comb begin
    step_o = '0;
    if (nxt == u8dec_pkg::StReject) begin
      step_o.next_state   = u8dec_pkg::StAccept;
      step_o.next_partial = '0;
      step_o.emit         = 1'b1;
      step_o.code_point   = u8dec_pkg::CpReplacement;
      step_o.invalid      = 1'b1;
    end else if (nxt == u8dec_pkg::StAccept) begin
      step_o.next_state   = u8dec_pkg::StAccept;
      step_o.next_partial = '0;
      step_o.emit         = 1'b1;
      step_o.code_point   = mapped;
      step_o.invalid      = 1'b0;
    end else begin
      step_o.next_state   = nxt;
      step_o.next_partial = gathered;
      step_o.emit         = 1'b0;
      step_o.code_point   = gathered;
      step_o.invalid      = 1'b0;
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_stream_decoder_with_case_core
// Streams directed and random UTF-8 text, broken sequences and noise bytes
// into the decoder under every case mode. A shadow decoder predicts each code
// point, and every result item is compared in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import u8dec_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned TimeoutNs   = 5_000_000;

  // Byte classes of the decoding automaton.
  localparam logic [3:0] ClsAscii   = 4'd0;
  localparam logic [3:0] ClsCont8   = 4'd1;
  localparam logic [3:0] ClsLead2   = 4'd2;
  localparam logic [3:0] ClsLead3   = 4'd3;
  localparam logic [3:0] ClsLeadEd  = 4'd4;
  localparam logic [3:0] ClsLeadF4  = 4'd5;
  localparam logic [3:0] ClsLead4   = 4'd6;
  localparam logic [3:0] ClsContA   = 4'd7;
  localparam logic [3:0] ClsIllegal = 4'd8;
  localparam logic [3:0] ClsCont9   = 4'd9;
  localparam logic [3:0] ClsLeadE0  = 4'd10;
  localparam logic [3:0] ClsLeadF0  = 4'd11;

  // Automaton states inside an open sequence.
  localparam logic [StateW-1:0] StNeed1   = 4'd2;
  localparam logic [StateW-1:0] StNeed2   = 4'd3;
  localparam logic [StateW-1:0] StAfterE0 = 4'd4;
  localparam logic [StateW-1:0] StAfterEd = 4'd5;
  localparam logic [StateW-1:0] StAfterF0 = 4'd6;
  localparam logic [StateW-1:0] StNeed3   = 4'd7;
  localparam logic [StateW-1:0] StAfterF4 = 4'd8;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           invalid;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  u8dec_in_if  in_ch ();
  u8dec_out_if out_ch ();
  u8dec_cfg_if cfg_ch ();

  // Shadow copy of the decoder state and its mode register.
  logic [StateW-1:0] dec_state;
  logic [CpW-1:0]    dec_partial;
  case_mode_e        dec_mode;
  decoded_t          expected_cps[$];

  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_pct     = 10;
  logic        hold_off     = 1'b0;
  logic [7:0]  enc_buf [4];

  utf8_stream_decoder_with_case_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Sorts a raw byte by its leading bits into the automaton's byte class.
  function automatic logic [3:0] classify_byte(input logic [7:0] b);
    logic [3:0] c;
    if (!b[7]) begin
      c = ClsAscii;
    end else if (!b[6]) begin
      if (b[5]) c = ClsContA;
      else if (b[4]) c = ClsCont9;
      else c = ClsCont8;
    end else if (!b[5]) begin
      c = (b[4:1] == 4'h0) ? ClsIllegal : ClsLead2;
    end else if (!b[4]) begin
      if (b == 8'hE0) c = ClsLeadE0;
      else if (b == 8'hED) c = ClsLeadEd;
      else c = ClsLead3;
    end else begin
      if (b == 8'hF0) c = ClsLeadF0;
      else if (b <= 8'hF3) c = ClsLead4;
      else if (b == 8'hF4) c = ClsLeadF4;
      else c = ClsIllegal;
    end
    return c;
  endfunction

  // Next automaton state; anything not allowed rejects the sequence.
  function automatic logic [StateW-1:0] advance(input logic [StateW-1:0] s,
                                                input logic [3:0] c);
    logic              any_cont;
    logic [StateW-1:0] n;
    any_cont = (c == ClsCont8) || (c == ClsCont9) || (c == ClsContA);
    n = StReject;
    case (s)
      StAccept: begin
        case (c)
          ClsAscii:  n = StAccept;
          ClsLead2:  n = StNeed1;
          ClsLead3:  n = StNeed2;
          ClsLead4:  n = StNeed3;
          ClsLeadE0: n = StAfterE0;
          ClsLeadEd: n = StAfterEd;
          ClsLeadF0: n = StAfterF0;
          ClsLeadF4: n = StAfterF4;
          default:   n = StReject;
        endcase
      end
      StNeed1:   if (any_cont) n = StAccept;
      StNeed2:   if (any_cont) n = StNeed1;
      StNeed3:   if (any_cont) n = StNeed2;
      // Overlong, surrogate and out-of-range second bytes are refused here.
      StAfterE0: if (c == ClsContA) n = StNeed1;
      StAfterEd: if (c == ClsCont8 || c == ClsCont9) n = StNeed1;
      StAfterF0: if (c == ClsContA || c == ClsCont9) n = StNeed2;
      StAfterF4: if (c == ClsCont8) n = StNeed2;
      default:   n = StReject;
    endcase
    return n;
  endfunction

  // ASCII case mapping; every other code point passes through.
  function automatic logic [CpW-1:0] apply_case(input logic [CpW-1:0] cp, input logic fc);
    logic to_up;
    logic to_low;
    to_up  = (dec_mode == CASE_UPPER) || (dec_mode == CASE_CAPITALIZE && fc);
    to_low = (dec_mode == CASE_LOWER);
    if (cp > CpAsciiMax) return cp;
    if (to_up && cp >= 21'h61 && cp <= 21'h7A) return cp - 21'h20;
    if (to_low && cp >= 21'h41 && cp <= 21'h5A) return cp + 21'h20;
    return cp;
  endfunction

  // Steps the shadow decoder by one byte; returns 1 when a result is due.
  function automatic logic decode_byte(input logic [7:0] b, input logic fc,
                                       output decoded_t res);
    logic [3:0]        c;
    logic [StateW-1:0] n;
    logic [CpW-1:0]    cp;
    c = classify_byte(b);
    if (dec_state != StAccept) dec_partial = {dec_partial[CpW-7:0], b[5:0]};
    else dec_partial = {{(CpW-ByteW){1'b0}}, (8'hFF >> c) & b};
    n = advance(dec_state, c);
    res = '0;
    if (n == StReject) begin
      dec_state = StAccept;
      dec_partial = '0;
      res.code_point = CpReplacement;
      res.invalid = 1'b1;
      return 1'b1;
    end
    if (n != StAccept) begin
      dec_state = n;
      return 1'b0;
    end
    cp = dec_partial;
    dec_state = StAccept;
    dec_partial = '0;
    res.code_point = apply_case(cp, fc);
    return 1'b1;
  endfunction

  // Writes the UTF-8 form of a code point into enc_buf and returns its length.
  function automatic int unsigned encode_cp(input int unsigned cp);
    if (cp < 'h80) begin
      enc_buf[0] = cp[7:0];
      return 1;
    end
    if (cp < 'h800) begin
      enc_buf[0] = {3'b110, cp[10:6]};
      enc_buf[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 'h10000) begin
      enc_buf[0] = {4'b1110, cp[15:12]};
      enc_buf[1] = {2'b10, cp[11:6]};
      enc_buf[2] = {2'b10, cp[5:0]};
      return 3;
    end
    enc_buf[0] = {5'b11110, cp[20:18]};
    enc_buf[1] = {2'b10, cp[17:12]};
    enc_buf[2] = {2'b10, cp[11:6]};
    enc_buf[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  // Random code point, weighted toward letters and the range boundaries.
  function automatic int unsigned pick_code_point();
    int unsigned r;
    int unsigned cp;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      cp = $urandom_range(0, 1) ? $urandom_range('h41, 'h5A) : $urandom_range('h61, 'h7A);
    end else if (r < 45) begin
      cp = $urandom_range(0, 'h7F);
    end else if (r < 60) begin
      cp = $urandom_range('h80, 'h7FF);
    end else if (r < 75) begin
      cp = $urandom_range('h800, 'hFFFF);
      // Surrogates are not encodable; move them into the upper BMP.
      if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
    end else if (r < 88) begin
      cp = $urandom_range('h10000, 'h10FFFF);
    end else begin
      case ($urandom_range(0, 7))
        0:       cp = 'h80;
        1:       cp = 'h7FF;
        2:       cp = 'h800;
        3:       cp = 'hD7FF;
        4:       cp = 'hE000;
        5:       cp = 'hFFFF;
        6:       cp = 'h10000;
        default: cp = 'h10FFFF;
      endcase
    end
    return cp;
  endfunction

  // Offers one byte, holds it until taken, then records the predicted result.
  task automatic send_byte(input logic [7:0] b, input logic fc);
    decoded_t res;
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.in_byte    = b;
    in_ch.first_char = fc;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    if (decode_byte(b, fc, res)) expected_cps = {expected_cps, res};
  endtask

  // Mostly well-formed characters, with noise bytes, cut and damaged sequences.
  task automatic send_random_text(input int unsigned n);
    int unsigned target;
    int unsigned len;
    int unsigned kind;
    logic        fc;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      fc   = 1'($urandom_range(0, 1));
      len  = encode_cp(pick_code_point());
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        enc_buf[0] = 8'($urandom_range(0, 255));
        len = 1;
      end else if (kind < 10 && len > 1) begin
        len = $urandom_range(1, len - 1);
      end else if (kind < 15 && len > 1) begin
        enc_buf[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < int'(len); i++) begin
        send_byte(enc_buf[i], ($urandom_range(0, 9) == 0) ? ~fc : fc);
      end
    end
  endtask

  // Stops offering items and lets the block drain completely.
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_case_mode(input case_mode_e m);
    wait_idle();
    @(negedge clk_i);
    cfg_ch.valid     = 1'b1;
    cfg_ch.case_mode = m;
    do @(posedge clk_i); while (!cfg_ch.ready);
    dec_mode = m;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Boundary code points of each length, then the typical malformed inputs.
  task automatic test_directed_sequences();
    send_byte(8'h00, 1'b0);  send_byte(8'h7F, 1'b1);
    send_byte(8'h61, 1'b1);  send_byte(8'h5A, 1'b0);
    send_byte(8'hC2, 1'b1);  send_byte(8'h80, 1'b1);
    send_byte(8'hDF, 1'b0);  send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b1);  send_byte(8'hA0, 1'b1);  send_byte(8'h80, 1'b1);
    send_byte(8'hED, 1'b0);  send_byte(8'h9F, 1'b0);  send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b1);  send_byte(8'h90, 1'b1);
    send_byte(8'h80, 1'b1);  send_byte(8'h80, 1'b1);
    send_byte(8'hF4, 1'b0);  send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);  send_byte(8'hBF, 1'b0);
    // Lone continuation, illegal lead, overlong three-byte form.
    send_byte(8'h80, 1'b1);  send_byte(8'hFF, 1'b0);
    send_byte(8'hE0, 1'b1);  send_byte(8'h80, 1'b1);
    // Sequence cut short by an ASCII byte, which is swallowed by the reject.
    send_byte(8'hC2, 1'b0);  send_byte(8'h41, 1'b0);
    wait_idle();
  endtask

  task automatic test_case_modes();
    case_mode_e order [4];
    order = '{CASE_UPPER, CASE_LOWER, CASE_CAPITALIZE, CASE_NONE};
    foreach (order[i]) begin
      write_case_mode(order[i]);
      send_random_text(180);
    end
  endtask

  // A long stretch where neither side ever idles.
  task automatic test_steady_stream();
    wait_idle();
    idle_pct = 0;
    send_random_text(200);
    wait_idle();
    idle_pct = 10;
  endtask

  // The receiver holds off while bytes keep coming, so the input must stall.
  task automatic test_backpressure();
    write_case_mode(CASE_CAPITALIZE);
    idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off = 1'b0;
      end
      send_random_text(60);
    join
    wait_idle();
    idle_pct = 10;
  endtask

  task automatic test_mode_shuffle();
    repeat (3) begin
      write_case_mode(case_mode_e'($urandom_range(0, 3)));
      send_random_text(100);
    end
  endtask

  // Output ready: random stalls, forced low during a hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ch.ready = 1'b0;
      else out_ch.ready = !(idle_pct != 0 && $urandom_range(0, 99) < idle_pct);
    end
  end

  // Each result item is checked against the oldest prediction.
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.invalid) invalid_seen++;
      if (expected_cps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected item code_point=%h invalid=%b",
                   $time, out_ch.code_point, out_ch.invalid);
        end
      end else begin
        want = expected_cps.pop_front();
        if (out_ch.code_point !== want.code_point || out_ch.invalid !== want.invalid) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: code_point=%h invalid=%b, expected code_point=%h invalid=%b",
                     $time, out_ch.code_point, out_ch.invalid,
                     want.code_point, want.invalid);
          end
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.first_char = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.case_mode = CASE_NONE;
    dec_state        = StAccept;
    dec_partial      = '0;
    dec_mode         = CASE_NONE;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_sequences();
    test_case_modes();
    test_steady_stream();
    test_backpressure();
    test_mode_shuffle();
    wait_idle();

    $display("Run covered %0d stream bytes and %0d decoded items, %0d of them replacements,",
             bytes_sent, results_seen, invalid_seen);
    $display("across all case modes with random stalls and a %0d-cycle output hold-off.",
             HoldCycles);
    if (mismatches == 0 && expected_cps.size() == 0) begin
      $display("utf8_stream_decoder_with_case_core: match");
    end else begin
      $display("utf8_stream_decoder_with_case_core: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TimeoutNs);
    $display("Timed out with %0d items still expected.", expected_cps.size());
    $display("utf8_stream_decoder_with_case_core: mismatch");
    $finish;
  end

endmodule
